FILE: sv/lpp_pkg.sv
`timescale 1ns / 1ps

package lpp_pkg;

	localparam int MAX_COMPONENTS   = 8;
	localparam int PHASE_COMPONENTS = 4;
	localparam int ONE_Q14          = 16384;

	// Sixteen root bits are found one per stage: the doubled ratio reaches 2^15.
	localparam int RATIO_STAGES = 16;
	localparam int PIPE_STAGES  = RATIO_STAGES + 1;
	localparam int ROOT_W       = RATIO_STAGES;
	localparam int MAG_W        = 15;
	localparam int REM_SHIFT    = 30;

	typedef logic signed [15:0] word_t;
	typedef logic [2:0]         comp_t;
	typedef logic [15:0]        abs_t;
	typedef logic [30:0]        sq_t;
	typedef logic [31:0]        sum_t;
	typedef logic [63:0]        wide_t;
	typedef logic [ROOT_W-1:0]  root_t;
	typedef logic [MAG_W-1:0]   mag_t;
	typedef logic [PIPE_STAGES-1:0]  stage_en_t;
	typedef logic [RATIO_STAGES-1:0] ratio_en_t;

	typedef struct packed {
		logic  four;
		logic  even;
		word_t copy_value;
	} meta_t;

	typedef struct packed {
		logic neg_re;
		logic neg_im;
		logic zero;
	} flags_t;

endpackage

FILE: sv/lpp_if.sv
`timescale 1ns / 1ps

interface lpp_in_if;
	import lpp_pkg::*;

	logic  valid;
	logic  ready;
	comp_t component;
	logic  x_parity;
	logic  y_parity;
	word_t link0_real;
	word_t link0_imag;
	word_t link1_real;
	word_t link1_imag;
	word_t copy_value;

	modport source (
		output valid, component, x_parity, y_parity,
		output link0_real, link0_imag, link1_real, link1_imag, copy_value,
		input  ready
	);
	modport sink (
		input  valid, component, x_parity, y_parity,
		input  link0_real, link0_imag, link1_real, link1_imag, copy_value,
		output ready
	);
endinterface

interface lpp_out_if;
	import lpp_pkg::*;

	logic  valid;
	logic  ready;
	word_t phase0_real;
	word_t phase0_imag;
	word_t phase1_real;
	word_t phase1_imag;
	word_t single_value;
	logic  writes_four;

	modport source (
		output valid, phase0_real, phase0_imag, phase1_real, phase1_imag,
		output single_value, writes_four,
		input  ready
	);
	modport sink (
		input  valid, phase0_real, phase0_imag, phase1_real, phase1_imag,
		input  single_value, writes_four,
		output ready
	);
endinterface

FILE: sv/link_phase_prolongation_top.sv
`timescale 1ns / 1ps

// Link phase prolongation for one fine lattice cell per item. Components 0 to 3
// return two unit phasors in Q2.14 (each coarse link divided by its magnitude,
// rounded to nearest with ties away from zero; a zero link gives 1.0) on cells
// with both parities even, and two unity links elsewhere; higher components
// return copy_value. A new item is taken every cycle unless the pipeline is full
// and the output is stalled. Each item passes through one stage that squares
// the link parts, sixteen stages that find the magnitude ratio one root bit each
// (four such pipelines run side by side, one per phasor part, in two link
// lanes), and one output register that merges the lanes. Items with a component
// at or above the component count are accepted and produce no result.
module link_phase_prolongation_top (
	input  logic      clk,
	input  logic      arst_n,
	lpp_in_if.sink    req,
	lpp_out_if.source rsp
);
	import lpp_pkg::*;

	logic       [PIPE_STAGES-1:0] v_q;
	meta_t      meta_q [PIPE_STAGES];
	stage_en_t  en;
	logic       out_free;
	logic       out_valid_q;
	logic       keep;
	word_t      unit0_re;
	word_t      unit0_im;
	word_t      unit1_re;
	word_t      unit1_im;
	meta_t      tail;
	word_t      p0_re_q;
	word_t      p0_im_q;
	word_t      p1_re_q;
	word_t      p1_im_q;
	word_t      single_q;
	logic       four_q;

	assign out_free = !out_valid_q || rsp.ready;

	// A stage may load when everything downstream of it can move or has a hole.
	for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_en
		assign en[i] = out_free || !(&v_q[PIPE_STAGES-1:i]);
	end

	assign req.ready = en[0];
	assign keep      = int'(req.component) < MAX_COMPONENTS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= req.valid && keep;
			end
			for (int i = 1; i < PIPE_STAGES; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			meta_q[0] <= '{four: int'(req.component) < PHASE_COMPONENTS,
				even: !req.x_parity && !req.y_parity, copy_value: req.copy_value};
		end
		for (int i = 1; i < PIPE_STAGES; i++) begin
			if (en[i]) begin
				meta_q[i] <= meta_q[i-1];
			end
		end
	end

	lpp_lane u_lane0 (
		.clk     (clk),
		.en      (en),
		.re      (req.link0_real),
		.im      (req.link0_imag),
		.unit_re (unit0_re),
		.unit_im (unit0_im)
	);

	lpp_lane u_lane1 (
		.clk     (clk),
		.en      (en),
		.re      (req.link1_real),
		.im      (req.link1_imag),
		.unit_re (unit1_re),
		.unit_im (unit1_im)
	);

	assign tail = meta_q[PIPE_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_q[PIPE_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			four_q <= tail.four;
			if (!tail.four) begin
				p0_re_q  <= '0;
				p0_im_q  <= '0;
				p1_re_q  <= '0;
				p1_im_q  <= '0;
				single_q <= tail.copy_value;
			end else if (tail.even) begin
				p0_re_q  <= unit0_re;
				p0_im_q  <= unit0_im;
				p1_re_q  <= unit1_re;
				p1_im_q  <= unit1_im;
				single_q <= '0;
			end else begin
				p0_re_q  <= word_t'(ONE_Q14);
				p0_im_q  <= '0;
				p1_re_q  <= word_t'(ONE_Q14);
				p1_im_q  <= '0;
				single_q <= '0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.phase0_real  = p0_re_q;
	assign rsp.phase0_imag  = p0_im_q;
	assign rsp.phase1_real  = p1_re_q;
	assign rsp.phase1_imag  = p1_im_q;
	assign rsp.single_value = single_q;
	assign rsp.writes_four  = four_q;

	a_copy_clears_phases : assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.writes_four |-> rsp.phase0_real == '0 && rsp.phase0_imag == '0
			&& rsp.phase1_real == '0 && rsp.phase1_imag == '0)
		else $error("copy item carries nonzero phase fields");

	a_phase_clears_single : assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.writes_four |-> rsp.single_value == '0)
		else $error("phase item carries a nonzero copied value");

	a_phase_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.writes_four |-> rsp.phase0_real <= word_t'(ONE_Q14)
			&& rsp.phase0_real >= -word_t'(ONE_Q14)
			&& rsp.phase1_imag <= word_t'(ONE_Q14)
			&& rsp.phase1_imag >= -word_t'(ONE_Q14))
		else $error("phasor part outside the unit range");

	a_empty_output_accepts : assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> req.ready)
		else $error("input stalled while the output register is empty");

endmodule

FILE: sv/lpp_ratio.sv
`timescale 1ns / 1ps

module lpp_ratio (
	input  logic               clk,
	input  lpp_pkg::ratio_en_t en,
	input  lpp_pkg::sq_t       a_sq,
	input  lpp_pkg::sum_t      s,
	output lpp_pkg::mag_t      q
);
	import lpp_pkg::*;

	// Finds u = floor(2^15 * a / sqrt(s)) one bit per stage. The remainder
	// a^2 * 2^30 - u^2 * s and the product u * s are kept so that every trial
	// is a shifted add and a compare.
	wide_t rem_s  [RATIO_STAGES-1];
	wide_t prod_s [RATIO_STAGES-1];
	sum_t  sum_s  [RATIO_STAGES-1];
	root_t root_s [RATIO_STAGES];

	for (genvar j = 0; j < RATIO_STAGES; j++) begin : g_step
		localparam int K = RATIO_STAGES - 1 - j;

		wide_t rem_in;
		wide_t prod_in;
		sum_t  sum_in;
		root_t root_in;
		wide_t inc;
		logic  take;

		if (j == 0) begin : g_first
			assign rem_in  = wide_t'(a_sq) << REM_SHIFT;
			assign prod_in = '0;
			assign sum_in  = s;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign prod_in = prod_s[j-1];
			assign sum_in  = sum_s[j-1];
			assign root_in = root_s[j-1];
		end

		// (u + 2^K)^2 * s - u^2 * s
		assign inc  = (prod_in << (K + 1)) + (wide_t'(sum_in) << (2 * K));
		assign take = (inc <= rem_in);

		always_ff @(posedge clk) begin
			if (en[j]) begin
				root_s[j] <= take ? (root_in | (root_t'(1) << K)) : root_in;
			end
		end

		if (j < RATIO_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[j]) begin
					sum_s[j]  <= sum_in;
					rem_s[j]  <= take ? (rem_in - inc) : rem_in;
					prod_s[j] <= take ? (prod_in + (wide_t'(sum_in) << K)) : prod_in;
				end
			end
		end
	end

	// Halving the doubled ratio with a carry in rounds to nearest, ties away.
	assign q = mag_t'(((ROOT_W + 1)'(root_s[RATIO_STAGES-1]) + (ROOT_W + 1)'(1)) >> 1);

endmodule

FILE: sv/lpp_lane.sv
`timescale 1ns / 1ps

module lpp_lane (
	input  logic               clk,
	input  lpp_pkg::stage_en_t en,
	input  lpp_pkg::word_t     re,
	input  lpp_pkg::word_t     im,
	output lpp_pkg::word_t     unit_re,
	output lpp_pkg::word_t     unit_im
);
	import lpp_pkg::*;

	abs_t       abs_re;
	abs_t       abs_im;
	logic [31:0] prod_re;
	logic [31:0] prod_im;
	sq_t        sq_re_s1;
	sq_t        sq_im_s1;
	sum_t       sum_s1;
	flags_t     flags_s [PIPE_STAGES];
	mag_t       mag_re;
	mag_t       mag_im;
	word_t      w_re;
	word_t      w_im;
	flags_t     last;

	// The most negative input negates onto itself, which reads as 2^15 unsigned.
	assign abs_re  = re[15] ? abs_t'(-re) : abs_t'(re);
	assign abs_im  = im[15] ? abs_t'(-im) : abs_t'(im);
	assign prod_re = abs_re * abs_re;
	assign prod_im = abs_im * abs_im;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sq_re_s1 <= sq_t'(prod_re);
			sq_im_s1 <= sq_t'(prod_im);
			sum_s1   <= sum_t'(prod_re) + sum_t'(prod_im);
			flags_s[0] <= '{neg_re: re[15], neg_im: im[15],
				zero: (re == '0) && (im == '0)};
		end
	end

	for (genvar i = 1; i < PIPE_STAGES; i++) begin : g_flags
		always_ff @(posedge clk) begin
			if (en[i]) begin
				flags_s[i] <= flags_s[i-1];
			end
		end
	end

	lpp_ratio u_ratio_re (
		.clk  (clk),
		.en   (en[PIPE_STAGES-1:1]),
		.a_sq (sq_re_s1),
		.s    (sum_s1),
		.q    (mag_re)
	);

	lpp_ratio u_ratio_im (
		.clk  (clk),
		.en   (en[PIPE_STAGES-1:1]),
		.a_sq (sq_im_s1),
		.s    (sum_s1),
		.q    (mag_im)
	);

	assign last = flags_s[PIPE_STAGES-1];
	assign w_re = word_t'(mag_re);
	assign w_im = word_t'(mag_im);

	always_comb begin
		if (last.zero) begin
			unit_re = word_t'(ONE_Q14);
			unit_im = '0;
		end else begin
			unit_re = last.neg_re ? -w_re : w_re;
			unit_im = last.neg_im ? -w_im : w_im;
		end
	end

endmodule

FILE: sim/tb_link_phase_prolongation_top.sv
`timescale 1ns / 1ps

module tb_link_phase_prolongation_top;
	import lpp_pkg::*;

	typedef struct packed {
		comp_t component;
		logic  x_parity;
		logic  y_parity;
		word_t link0_real;
		word_t link0_imag;
		word_t link1_real;
		word_t link1_imag;
		word_t copy_value;
	} cell_item_t;

	typedef struct packed {
		word_t phase0_real;
		word_t phase0_imag;
		word_t phase1_real;
		word_t phase1_imag;
		word_t single_value;
		logic  writes_four;
	} cell_result_t;

	typedef struct packed {
		cell_item_t   item;
		logic         typed;
		cell_result_t want;
	} directed_row_t;

	localparam int RANDOM_PER_PHASE = 344;
	localparam int DRAIN_CYCLES     = 40;
	localparam int PRINT_CAP        = 100;

	logic clk;
	logic arst_n;

	lpp_in_if  req_if ();
	lpp_out_if rsp_if ();

	link_phase_prolongation_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	cell_result_t  expected_cells[$];
	directed_row_t directed_rows[$];
	int            mismatch_count  = 0;
	int            sender_idle_pct = 7;
	int            sink_idle_pct   = 57;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	// Largest m with (m - 1/2) <= 16384 * mag / sqrt(sum_sq), i.e. the rounded ratio
	// with ties going away from zero; both sides are squared to stay in integers.
	function automatic word_t q14_ratio(input longint unsigned mag, input longint unsigned sum_sq);
		longint unsigned bound, lo, hi, mid, odd;
		bound = (mag * mag) << 30;
		lo = 0;
		hi = ONE_Q14;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			odd = 2 * mid - 1;
			if (odd * odd * sum_sq <= bound)
				lo = mid;
			else
				hi = mid - 1;
		end
		return word_t'(lo);
	endfunction

	function automatic void normalize_link(input word_t re, input word_t im,
			output word_t out_re, output word_t out_im);
		longint          sre, sim;
		longint unsigned mag_re, mag_im, sum_sq;
		sre    = re;
		sim    = im;
		mag_re = (sre < 0) ? -sre : sre;
		mag_im = (sim < 0) ? -sim : sim;
		sum_sq = mag_re * mag_re + mag_im * mag_im;
		if (sum_sq == 0) begin
			out_re = word_t'(ONE_Q14);
			out_im = '0;
		end else begin
			out_re = q14_ratio(mag_re, sum_sq);
			out_im = q14_ratio(mag_im, sum_sq);
			if (sre < 0)
				out_re = -out_re;
			if (sim < 0)
				out_im = -out_im;
		end
	endfunction

	function automatic bit predict_cell(input cell_item_t c, output cell_result_t r);
		r = '0;
		if (int'(c.component) >= MAX_COMPONENTS)
			return 1'b0;
		if (int'(c.component) < PHASE_COMPONENTS) begin
			if (!c.x_parity && !c.y_parity) begin
				normalize_link(c.link0_real, c.link0_imag, r.phase0_real, r.phase0_imag);
				normalize_link(c.link1_real, c.link1_imag, r.phase1_real, r.phase1_imag);
			end else begin
				r.phase0_real = word_t'(ONE_Q14);
				r.phase1_real = word_t'(ONE_Q14);
			end
			r.writes_four = 1'b1;
		end else begin
			r.single_value = c.copy_value;
		end
		return 1'b1;
	endfunction

	function automatic cell_item_t mk_item(input int comp, input int xp, input int yp,
			input int l0r, input int l0i, input int l1r, input int l1i, input int cv);
		cell_item_t c;
		c.component  = comp_t'(comp);
		c.x_parity   = xp[0];
		c.y_parity   = yp[0];
		c.link0_real = word_t'(l0r);
		c.link0_imag = word_t'(l0i);
		c.link1_real = word_t'(l1r);
		c.link1_imag = word_t'(l1i);
		c.copy_value = word_t'(cv);
		return c;
	endfunction

	function automatic cell_result_t mk_result(input int p0r, input int p0i, input int p1r,
			input int p1i, input int sv, input int four);
		cell_result_t r;
		r.phase0_real  = word_t'(p0r);
		r.phase0_imag  = word_t'(p0i);
		r.phase1_real  = word_t'(p1r);
		r.phase1_imag  = word_t'(p1i);
		r.single_value = word_t'(sv);
		r.writes_four  = four[0];
		return r;
	endfunction

	task automatic add_row(input cell_item_t c, input logic typed, input cell_result_t want);
		directed_row_t row;
		row.item  = c;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// Link parts lean toward zero, the extremes and small magnitudes, where the
	// rounding of the ratio is hardest.
	function automatic word_t random_link_part();
		case ($urandom_range(9))
			0: return '0;
			1: return 16'sh8000;
			2: return 16'sh7fff;
			3: return word_t'(int'($urandom_range(32)) - 16);
			4: return $urandom_range(1) ? word_t'(ONE_Q14) : word_t'(-ONE_Q14);
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic cell_item_t random_cell();
		cell_item_t c;
		c.component = comp_t'($urandom_range(7));
		if ($urandom_range(99) < 60) begin
			c.x_parity = 1'b0;
			c.y_parity = 1'b0;
		end else begin
			c.x_parity = 1'($urandom_range(1));
			c.y_parity = 1'($urandom_range(1));
		end
		c.link0_real = random_link_part();
		c.link0_imag = random_link_part();
		c.link1_real = random_link_part();
		c.link1_imag = random_link_part();
		if ($urandom_range(19) == 0) begin
			c.link0_real = '0;
			c.link0_imag = '0;
		end
		if ($urandom_range(19) == 0) begin
			c.link1_real = '0;
			c.link1_imag = '0;
		end
		c.copy_value = word_t'($urandom);
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d (0x%h), expected %0d (0x%h)",
				name, $signed(got), got, $signed(want), want));
	endtask

	task automatic check_result(input cell_result_t got);
		cell_result_t want;
		if (expected_cells.size() == 0) begin
			report_mismatch("result with no item waiting for it");
			return;
		end
		want = expected_cells.pop_front();
		check_field("phase0_real", got.phase0_real, want.phase0_real);
		check_field("phase0_imag", got.phase0_imag, want.phase0_imag);
		check_field("phase1_real", got.phase1_real, want.phase1_real);
		check_field("phase1_imag", got.phase1_imag, want.phase1_imag);
		check_field("single_value", got.single_value, want.single_value);
		check_field("writes_four", 16'(got.writes_four), 16'(want.writes_four));
	endtask

	task automatic send_cell(input cell_item_t c, input logic typed, input cell_result_t want);
		cell_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.component  <= c.component;
		req_if.x_parity   <= c.x_parity;
		req_if.y_parity   <= c.y_parity;
		req_if.link0_real <= c.link0_real;
		req_if.link0_imag <= c.link0_imag;
		req_if.link1_real <= c.link1_real;
		req_if.link1_imag <= c.link1_imag;
		req_if.copy_value <= c.copy_value;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		if (typed)
			expected_cells.push_back(want);
		else if (predict_cell(c, predicted))
			expected_cells.push_back(predicted);
	endtask

	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			check_result(mk_result(int'(rsp_if.phase0_real), int'(rsp_if.phase0_imag),
				int'(rsp_if.phase1_real), int'(rsp_if.phase1_imag),
				int'(rsp_if.single_value), int'(rsp_if.writes_four)));
	end

	initial begin
		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.component  = '0;
		req_if.x_parity   = 1'b0;
		req_if.y_parity   = 1'b0;
		req_if.link0_real = '0;
		req_if.link0_imag = '0;
		req_if.link1_real = '0;
		req_if.link1_imag = '0;
		req_if.copy_value = '0;
		rsp_if.ready      = 1'b0;

		// Zero links, axis extremes, odd parities and copies have results known by hand.
		add_row(mk_item(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_result(16384, 0, 16384, 0, 0, 1));
		add_row(mk_item(1, 0, 0, 16384, 0, 0, 16384, 77), 1'b1,
			mk_result(16384, 0, 0, 16384, 0, 1));
		add_row(mk_item(2, 0, 0, -32768, 0, 0, -32768, -5), 1'b1,
			mk_result(-16384, 0, 0, -16384, 0, 1));
		add_row(mk_item(3, 0, 0, 32767, 0, 0, 32767, 32767), 1'b1,
			mk_result(16384, 0, 0, 16384, 0, 1));
		add_row(mk_item(3, 0, 0, 1, 0, 0, -1, 0), 1'b1,
			mk_result(16384, 0, 0, -16384, 0, 1));
		add_row(mk_item(0, 1, 0, -32768, 32767, 123, -456, 9), 1'b1,
			mk_result(16384, 0, 16384, 0, 0, 1));
		add_row(mk_item(3, 0, 1, 0, 0, -32768, -32768, 0), 1'b1,
			mk_result(16384, 0, 16384, 0, 0, 1));
		add_row(mk_item(2, 1, 1, 32767, 32767, 1, 1, -1), 1'b1,
			mk_result(16384, 0, 16384, 0, 0, 1));
		add_row(mk_item(4, 0, 0, 1000, 2000, 3000, 4000, 32767), 1'b1,
			mk_result(0, 0, 0, 0, 32767, 0));
		add_row(mk_item(5, 0, 0, -32768, -32768, 32767, 32767, -32768), 1'b1,
			mk_result(0, 0, 0, 0, -32768, 0));
		add_row(mk_item(6, 1, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_result(0, 0, 0, 0, 0, 0));
		add_row(mk_item(7, 0, 1, 5, 5, 5, 5, -1), 1'b1,
			mk_result(0, 0, 0, 0, -1, 0));
		add_row(mk_item(4, 1, 1, -1, -1, -1, -1, 4660), 1'b1,
			mk_result(0, 0, 0, 0, 4660, 0));
		add_row(mk_item(0, 0, 0, -32768, -32768, 32767, 32767, 0), 1'b0, '0);
		add_row(mk_item(1, 0, 0, 1, 1, -1, 1, 0), 1'b0, '0);
		add_row(mk_item(2, 0, 0, 3, 4, -3, -4, 0), 1'b0, '0);
		add_row(mk_item(0, 0, 0, -1, 0, -32768, 32767, 0), 1'b0, '0);
		add_row(mk_item(1, 0, 0, 32767, -32768, -32767, 1, 0), 1'b0, '0);
		add_row(mk_item(3, 0, 0, 12345, -23456, -7, 3, 0), 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_cell(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 7;
					sink_idle_pct   = 57;
				end
				1: begin
					sender_idle_pct = 57;
					sink_idle_pct   = 7;
				end
				default: begin
					sender_idle_pct = 0;
					sink_idle_pct   = 0;
				end
			endcase
			repeat (RANDOM_PER_PHASE)
				send_cell(random_cell(), 1'b0, '0);
		end
		req_if.valid <= 1'b0;

		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
